>>> sv/pn3_pkg.sv
package pn3_pkg;

  localparam int FracBitsDefault = 16;
  localparam int IntBits = 8;
  localparam int CoordW = 24;
  localparam int OutW = 17;

  typedef logic [7:0] perm_t;

  function automatic perm_t perm_rom(input logic [7:0] idx);
    perm_t r;
    unique case (idx)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/pn3_fade.sv
// Quintic fade 6t^5-15t^4+10t^3, four multiplies over three register stages,
// advances on en.
module pn3_fade #(
  parameter int FRAC_BITS = pn3_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   f
);
  localparam int W = FRAC_BITS + 6;
  localparam int PW = 2 * W;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [W-1:0] One = W'(1) <<< FRAC_BITS;
  localparam logic signed [W-1:0] Ten = W'(10) <<< FRAC_BITS;

  logic signed [W-1:0] t0, t1, tt1, inner1, t2r, inner2, t3r, inner3;
  logic signed [PW-1:0] p_inner, p_t2, p_t3, p_f;
  logic signed [W-1:0] q_f;

  always_comb begin
    t0 = W'(t);
    p_inner = PW'(t0) * PW'(6 * t0 - 15 * One) + Half;
    p_t2 = PW'(t0) * PW'(t0) + Half;
  end

  // t*t and the inner polynomial
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t0;
      inner1 <= W'(p_inner >>> FRAC_BITS) + Ten;
      t2r <= W'(p_t2 >>> FRAC_BITS);
    end
  end

  assign p_t3 = PW'(t2r) * PW'(t1) + Half;

  always_ff @(posedge clk) begin
    if (en) begin
      t3r <= W'(p_t3 >>> FRAC_BITS);
      inner2 <= inner1;
    end
  end

  assign tt1 = t3r;
  assign p_f = PW'(tt1) * PW'(inner2) + Half;
  assign q_f = W'(p_f >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      inner3 <= q_f;
    end
  end

  always_comb begin
    if (inner3 < 0) f = '0;
    else if (inner3 > One) f = (FRAC_BITS+1)'(One);
    else f = inner3[FRAC_BITS:0];
  end
endmodule

>>> sv/perlin_noise_3d_core.sv
// Channel | Direction | Handshake          | Beat
// in      | in        | in_valid/in_stall  | x_coord, y_coord, z_coord
// out     | out       | out_valid/out_stall| noise_value
//
// One point per cycle sustained while out_stall does not hold the pipe; nine
// register stages, and out_valid rises when the beat reaches the last of them.
// Stages: hash lookups (three ROM levels), fade (three multiply stages),
// three trilinear lerp levels, output scaling. The whole pipe advances when
// the output register is empty or being taken; stall freezes every stage.
// Synchronous reset clears valid bits only; the ROM is constant.
module perlin_noise_3d_core #(
  parameter int FRAC_BITS = pn3_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] x_coord,
  input  logic [23:0] y_coord,
  input  logic [23:0] z_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] noise_value
);
  localparam int F = FRAC_BITS;
  localparam int W = F + 4;        // signed values, |v| < 8
  localparam int PW = 2 * W;
  localparam int NST = 9;
  localparam logic signed [W-1:0] One = W'(1) <<< F;
  localparam logic signed [W-1:0] Two = One <<< 1;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (F - 1);
  localparam int ShR = (F > 15) ? F - 15 : 0;
  localparam int ShL = (F > 15) ? 0 : 15 - F;
  localparam logic signed [W-1:0] RoundBit = W'((1 << ShR) >> 1);

  logic adv;
  logic [NST-1:0] vld;

  // advance whenever the final register is free or drained
  assign adv = !vld[NST-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 1: capture coordinates, first hash level
  logic [7:0] xi1, yi1, zi1;
  logic [F-1:0] xf1, yf1, zf1;
  logic [7:0] a1, b1;
  always_ff @(posedge clk) begin
    if (adv) begin
      xi1 <= x_coord[F+7:F];
      yi1 <= y_coord[F+7:F];
      zi1 <= z_coord[F+7:F];
      xf1 <= x_coord[F-1:0];
      yf1 <= y_coord[F-1:0];
      zf1 <= z_coord[F-1:0];
    end
  end
  assign a1 = pn3_pkg::perm_rom(xi1) + yi1;
  assign b1 = pn3_pkg::perm_rom(xi1 + 8'd1) + yi1;

  // stage 2: second hash level
  logic [7:0] zi2, aa2, ab2, ba2, bb2;
  logic [F-1:0] xf2, yf2, zf2;
  logic [7:0] a2, b2;
  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= a1; b2 <= b1; zi2 <= zi1;
      xf2 <= xf1; yf2 <= yf1; zf2 <= zf1;
    end
  end
  assign aa2 = pn3_pkg::perm_rom(a2) + zi2;
  assign ab2 = pn3_pkg::perm_rom(a2 + 8'd1) + zi2;
  assign ba2 = pn3_pkg::perm_rom(b2) + zi2;
  assign bb2 = pn3_pkg::perm_rom(b2 + 8'd1) + zi2;

  // stage 3: corner hashes
  logic [7:0] aa3, ab3, ba3, bb3;
  logic [F-1:0] xf3, yf3, zf3;
  logic [7:0] p3 [8];
  logic [3:0] h3 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      aa3 <= aa2; ab3 <= ab2; ba3 <= ba2; bb3 <= bb2;
      xf3 <= xf2; yf3 <= yf2; zf3 <= zf2;
    end
  end
  always_comb begin
    p3[0] = pn3_pkg::perm_rom(aa3);
    p3[1] = pn3_pkg::perm_rom(ba3);
    p3[2] = pn3_pkg::perm_rom(ab3);
    p3[3] = pn3_pkg::perm_rom(bb3);
    p3[4] = pn3_pkg::perm_rom(aa3 + 8'd1);
    p3[5] = pn3_pkg::perm_rom(ba3 + 8'd1);
    p3[6] = pn3_pkg::perm_rom(ab3 + 8'd1);
    p3[7] = pn3_pkg::perm_rom(bb3 + 8'd1);
    for (int c = 0; c < 8; c++) h3[c] = p3[c][3:0];
  end

  // stage 4: gradients, corner c has offset bit0=x, bit1=y, bit2=z
  logic signed [W-1:0] g4 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        logic signed [W-1:0] gx, gy, gz, gu, gv;
        gx = W'(xf3) - (c[0] ? One : W'(0));
        gy = W'(yf3) - (c[1] ? One : W'(0));
        gz = W'(zf3) - (c[2] ? One : W'(0));
        gu = (h3[c] < 4'd8) ? gx : gy;
        gv = (h3[c] < 4'd4) ? gy : ((h3[c] == 4'd12 || h3[c] == 4'd14) ? gx : gz);
        g4[c] <= (h3[c][0] ? -gu : gu) + (h3[c][1] ? -gv : gv);
      end
    end
  end

  // fades start from the stage 3 fractions so they line up at stage 6
  logic [F:0] fu, fv, fw;
  pn3_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(adv), .t(xf3), .f(fu));
  pn3_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(adv), .t(yf3), .f(fv));
  pn3_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(adv), .t(zf3), .f(fw));

  // fade pipe: inputs at stage 3, valid after three regs (stage 6)
  // gradients delayed to stage 6 too
  logic signed [W-1:0] g5 [8], g6 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      g5 <= g4;
      g6 <= g5;
    end
  end

  function automatic logic signed [W-1:0] lerp(input logic [F:0] t,
      input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(signed'({1'b0, t})) * PW'(b - a) + Half;
    return a + W'(p >>> F);
  endfunction

  // stage 6 -> 7: x lerps; hold fades along
  logic signed [W-1:0] lx7 [4];
  logic [F:0] fv7, fw7, fw8;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) lx7[k] <= lerp(fu, g6[2*k], g6[2*k+1]);
      fv7 <= fv;
      fw7 <= fw;
    end
  end

  // y lerps
  logic signed [W-1:0] ly8 [2];
  always_ff @(posedge clk) begin
    if (adv) begin
      ly8[0] <= lerp(fv7, lx7[0], lx7[1]);
      ly8[1] <= lerp(fv7, lx7[2], lx7[3]);
      fw8 <= fw7;
    end
  end

  // z lerp, offset, saturate, rescale into the output register
  logic signed [W-1:0] n8, s8;
  logic [16:0] r8;
  always_comb begin
    n8 = lerp(fw8, ly8[0], ly8[1]);
    s8 = n8 + One;
    if (s8 < 0) s8 = '0;
    if (s8 > Two) s8 = Two;
    if (F > 15) r8 = 17'((s8 + RoundBit) >>> ShR);
    else r8 = 17'(s8) <<< ShL;
  end

  logic [16:0] out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= r8;
    end
  end
  assign noise_value = out_r;
endmodule
